FILE: src/bilinear_stress_profile_fit_assert.svh
// ----------------------------------------------------------------------------
// bilinear stress profile fit assertion macros
// concurrent checks sampled on clock, off while reset is high
// ----------------------------------------------------------------------------
`ifndef BILINEAR_STRESS_PROFILE_FIT_ASSERT_SVH
`define BILINEAR_STRESS_PROFILE_FIT_ASSERT_SVH

// same-cycle implication
`define BSPF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSPF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bspf_pkg.sv
// ----------------------------------------------------------------------------
// bspf_pkg
// shared types, codes and helpers of the bilinear stress profile fit
// ----------------------------------------------------------------------------
package bspf_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam logic REG_LIMIT = 1'b0;
   localparam logic [31:0] LIMIT_RESET = 32'd655;
   localparam logic [40:0] QUOT_CLAMP = 41'h100_0000_0000;

   typedef enum logic [3:0] {
      OP_NONE, OP_FIRST, OP_LOAD, OP_MUL, OP_ACC, OP_EVAL, OP_DIV_A,
      OP_BAND, OP_KMUL, OP_DIV_P, OP_TERM, OP_KINK, OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      SEL_FAIL, SEL_FIRST, SEL_KINK, SEL_LAST
   } sel_type;

   typedef enum logic [1:0] {
      FIT_FAIL = 2'd0, FIT_LIN = 2'd1, FIT_BIL = 2'd2
   } fit_type;

   typedef struct packed {
      op_type  op;
      logic [2:0] step;
      logic    use_first;
      sel_type sel;
      fit_type fit;
   } cmd_type;

   typedef struct packed {
      logic nsmall;
      logic a_gt;
      logic a_lt;
      logic b_zero;
      logic div_busy;
      logic pass_band;
      logic out_free;
   } sts_type;

   function automatic logic signed [15:0] sat16(input logic signed [43:0] v);
      if (v > 44'sd32767) begin
         return 16'sh7fff;
      end else if (v < -44'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

FILE: src/bspf_if.sv
// ----------------------------------------------------------------------------
// bspf_if
// point and result channels, valid/ready
// ----------------------------------------------------------------------------
interface bspf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pos_y;
   logic signed [15:0] stress;
   logic               is_last;

   modport source (output valid, pos_y, stress, is_last, input ready);
   modport sink (input valid, pos_y, stress, is_last, output ready);
endinterface

interface bspf_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         fit_status;
   logic signed [15:0] out_y;
   logic signed [15:0] out_stress;
   logic               out_last;

   modport source (output valid, fit_status, out_y, out_stress, out_last, input ready);
   modport sink (input valid, fit_status, out_y, out_stress, out_last, output ready);
endinterface

FILE: src/bilinear_stress_profile_fit.sv
// ----------------------------------------------------------------------------
// bilinear_stress_profile_fit
// bilinear fit of a piecewise-linear stress profile in q8.8
// ----------------------------------------------------------------------------
// usage:
//   req carries one profile point a beat (pos_y, stress, is_last); rsp carries
//   result beats (fit_status, out_y, out_stress, out_last), out_last on the
//   final beat of a profile: one fail beat, two end points, or three points.
//   bilin_limit sits at byte address 0 of the apb port; write it while idle.
// sequence:
//   a first point is only stored; any later point runs one shared multiplier
//   through six products, then the sums update. the last point runs
//   the six products again against the first point, then the tests; when the
//   line fit decides, the result beats follow the tests. the bilinear path
//   runs the radix-2 divider three times before the first beat, then gives
//   one beat a cycle while rsp is ready.
//   a single-point profile goes straight to the emit state for its fail beat.
// reset:
//   the profile closes, sums and points clear, bilin_limit returns to 655.
// stall:
//   results wait in an output register; while rsp is stalled the sequencer
//   holds at its next beat and req stays not ready until the profile is done.
// ----------------------------------------------------------------------------
module bilinear_stress_profile_fit
   import bspf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bspf_req_if.sink              req,
   bspf_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [31:0] limit_ff, limit_in;
   cmd_type     cmd;
   sts_type     sts;
   logic        in_ready;

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
         limit_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_LIMIT) ? limit_ff : 32'd0;
   assign req.ready = in_ready;

   bspf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_last  (req.is_last),
      .in_ready (in_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   bspf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_pos_y   (req.pos_y),
      .in_stress  (req.stress),
      .limit      (limit_ff),
      .rsp_ready  (rsp.ready),
      .rsp_valid  (rsp.valid),
      .fit_status (rsp.fit_status),
      .out_y      (rsp.out_y),
      .out_stress (rsp.out_stress),
      .out_last   (rsp.out_last)
   );

endmodule

FILE: src/bspf_div.sv
// ----------------------------------------------------------------------------
// bspf_div
// unsigned 64 by 64 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bspf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        busy,
   output logic [63:0] quo,
   output logic [63:0] rem
);

   logic [63:0] quo_ff, quo_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] shifted;
   logic        ge;

   always_comb begin
      shifted = {rem_ff[63:0], quo_ff[63]};
      ge = shifted >= {1'b0, den_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? shifted - {1'b0, den_ff} : shifted;
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff - 7'd1;
         busy_in = cnt_ff != 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign quo = quo_ff;
   assign rem = rem_ff[63:0];

endmodule

FILE: src/bspf_dp.sv
// ----------------------------------------------------------------------------
// bspf_dp
// running sums, shared multiplier, deviation tests, kink point, result register
// ----------------------------------------------------------------------------
module bspf_dp
   import bspf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic signed [15:0] in_pos_y,
   input  logic signed [15:0] in_stress,
   input  logic [31:0]        limit,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [1:0]         fit_status,
   output logic signed [15:0] out_y,
   output logic signed [15:0] out_stress,
   output logic               out_last
);

   logic signed [15:0] in_y_ff, in_y_in, in_s_ff, in_s_in;
   logic signed [15:0] first_y_ff, first_y_in, first_s_ff, first_s_in;
   logic signed [15:0] prev_y_ff, prev_y_in, prev_s_ff, prev_s_in;
   logic [47:0]        sum_f_ff, sum_f_in;
   logic [63:0]        sum_m_ff, sum_m_in;
   logic signed [35:0] inner_ff, inner_in;
   logic signed [33:0] lf_ff, lf_in;
   logic signed [52:0] lm_ff, lm_in;
   logic signed [48:0] b_ff, b_in;
   logic signed [63:0] a_ff, a_in;
   logic signed [42:0] y0_ff, y0_in;
   logic signed [57:0] kprod_ff, kprod_in;
   logic signed [39:0] term_ff, term_in;
   logic signed [43:0] snew_ff, snew_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         fit_ff, fit_in;
   logic signed [15:0] out_y_ff, out_y_in, out_s_ff, out_s_in;
   logic               out_last_ff, out_last_in;

   logic signed [15:0] ya, sa;
   logic signed [16:0] d, ssum, dy, sdiff;
   logic signed [39:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [57:0] mul_p;
   logic signed [35:0] p36;
   logic [48:0]        bm;
   logic [63:0]        am, kmag;
   logic [42:0]        lim6;
   logic [33:0]        lim2;
   logic               div_start, div_busy;
   logic [63:0]        div_num, div_den, quo, rem;
   logic [40:0]        qm;
   logic signed [41:0] q42, tr, fl, k1, k2;
   logic               neg, remnz;

   bspf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (quo),
      .rem   (rem)
   );

   always_comb begin
      ya = cmd.use_first ? first_y_ff : prev_y_ff;
      sa = cmd.use_first ? first_s_ff : prev_s_ff;
      d = 17'(in_y_ff) - 17'(ya);
      ssum = 17'(sa) + 17'(in_s_ff);
      dy = 17'(in_y_ff) - 17'(first_y_ff);
      sdiff = 17'(in_s_ff) - 17'(first_s_ff);

      mul_a = '0;
      mul_b = '0;
      if (cmd.op == OP_KMUL) begin
         mul_a = 40'(y0_ff - 43'(first_y_ff));
         mul_b = 18'(sdiff);
      end else begin
         case (cmd.step)
            3'd0: begin mul_a = 40'(sa); mul_b = 18'(ya); end
            3'd1: begin mul_a = 40'(sa); mul_b = 18'(in_y_ff); end
            3'd2: begin mul_a = 40'(in_s_ff); mul_b = 18'(ya); end
            3'd3: begin mul_a = 40'(in_s_ff); mul_b = 18'(in_y_ff); end
            3'd4: begin mul_a = 40'(d); mul_b = 18'(ssum); end
            3'd5: begin mul_a = 40'(inner_ff); mul_b = 18'(d); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
      mul_p = 58'(mul_a) * 58'(mul_b);
      p36 = 36'(mul_p);

      bm = b_ff[48] ? 49'(-b_ff) : 49'(b_ff);
      am = a_ff[63] ? 64'(-a_ff) : 64'(a_ff);
      kmag = kprod_ff[57] ? 64'(-kprod_ff) : 64'(kprod_ff);
      lim2 = {1'b0, limit, 1'b0};
      lim6 = 43'({limit, 10'b0}) + 43'({limit, 9'b0});

      // ratio band check from the first division
      qm = (quo > 64'(QUOT_CLAMP)) ? QUOT_CLAMP : quo[40:0];
      remnz = rem != 64'd0;
      neg = a_ff[63] ^ b_ff[48];
      q42 = signed'({1'b0, qm});
      tr = neg ? -q42 : q42;
      fl = (neg && remnz) ? tr - 42'sd1 : tr;
      k1 = (42'(first_y_ff) <<< 1) + 42'(in_y_ff);
      k2 = 42'(first_y_ff) + (42'(in_y_ff) <<< 1);

      div_start = (cmd.op == OP_DIV_A) || (cmd.op == OP_DIV_P) || (cmd.op == OP_TERM);
      div_num = 64'(bm);
      div_den = 64'(unsigned'(dy));
      case (cmd.op)
         OP_DIV_A: begin div_num = am; div_den = 64'(bm); end
         OP_DIV_P: div_num = kmag;
         default: div_num = 64'(bm);
      endcase

      sts.nsmall = bm < 49'(lim2);
      sts.a_gt = am > 64'(lim6);
      sts.a_lt = am < 64'(lim6);
      sts.b_zero = b_ff == 49'sd0;
      sts.div_busy = div_busy;
      sts.pass_band = ((fl > k1) || ((fl == k1) && remnz)) && (fl < k2);
      sts.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      in_y_in = in_y_ff;
      in_s_in = in_s_ff;
      first_y_in = first_y_ff;
      first_s_in = first_s_ff;
      prev_y_in = prev_y_ff;
      prev_s_in = prev_s_ff;
      sum_f_in = sum_f_ff;
      sum_m_in = sum_m_ff;
      inner_in = inner_ff;
      lf_in = lf_ff;
      lm_in = lm_ff;
      b_in = b_ff;
      a_in = a_ff;
      y0_in = y0_ff;
      kprod_in = kprod_ff;
      term_in = term_ff;
      snew_in = snew_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      fit_in = fit_ff;
      out_y_in = out_y_ff;
      out_s_in = out_s_ff;
      out_last_in = out_last_ff;
      case (cmd.op)
         OP_FIRST: begin
            in_y_in = in_pos_y;
            in_s_in = in_stress;
            first_y_in = in_pos_y;
            first_s_in = in_stress;
            prev_y_in = in_pos_y;
            prev_s_in = in_stress;
            sum_f_in = '0;
            sum_m_in = '0;
         end
         OP_LOAD: begin
            in_y_in = in_pos_y;
            in_s_in = in_stress;
         end
         OP_MUL: begin
            case (cmd.step)
               3'd0: inner_in = p36 <<< 1;
               3'd1: inner_in = inner_ff + p36;
               3'd2: inner_in = inner_ff + p36;
               3'd3: inner_in = inner_ff + (p36 <<< 1);
               3'd4: lf_in = 34'(mul_p);
               3'd5: lm_in = 53'(mul_p);
               default: inner_in = inner_ff;
            endcase
         end
         OP_ACC: begin
            sum_f_in = sum_f_ff + 48'(lf_ff);
            sum_m_in = sum_m_ff + 64'(lm_ff);
            prev_y_in = in_y_ff;
            prev_s_in = in_s_ff;
         end
         OP_EVAL: begin
            b_in = 49'(signed'(sum_f_ff)) - 49'(lf_ff);
            a_in = signed'(sum_m_ff - 64'(lm_ff));
         end
         OP_BAND: y0_in = 43'(tr) - 43'(first_y_ff) - 43'(in_y_ff);
         OP_KMUL: kprod_in = mul_p;
         OP_TERM: term_in = kprod_ff[57] ? -signed'(quo[39:0]) : signed'(quo[39:0]);
         OP_KINK: begin
            // force quotient, clamped, carries the sign of the force deviation
            snew_in = 44'(first_s_ff) + 44'(term_ff) + 44'(b_ff[48] ? -q42 : q42);
         end
         OP_EMIT: begin
            rsp_valid_in = 1'b1;
            fit_in = cmd.fit;
            case (cmd.sel)
               SEL_FIRST: begin
                  out_y_in = first_y_ff;
                  out_s_in = first_s_ff;
                  out_last_in = 1'b0;
               end
               SEL_KINK: begin
                  out_y_in = sat16(44'(y0_ff));
                  out_s_in = sat16(snew_ff);
                  out_last_in = 1'b0;
               end
               SEL_LAST: begin
                  out_y_in = in_y_ff;
                  out_s_in = in_s_ff;
                  out_last_in = 1'b1;
               end
               default: begin
                  out_y_in = '0;
                  out_s_in = '0;
                  out_last_in = 1'b1;
               end
            endcase
         end
         default: begin
            in_y_in = in_y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         first_y_ff <= '0;
         first_s_ff <= '0;
         prev_y_ff <= '0;
         prev_s_ff <= '0;
         sum_f_ff <= '0;
         sum_m_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         first_y_ff <= first_y_in;
         first_s_ff <= first_s_in;
         prev_y_ff <= prev_y_in;
         prev_s_ff <= prev_s_in;
         sum_f_ff <= sum_f_in;
         sum_m_ff <= sum_m_in;
      end
      in_y_ff <= in_y_in;
      in_s_ff <= in_s_in;
      inner_ff <= inner_in;
      lf_ff <= lf_in;
      lm_ff <= lm_in;
      b_ff <= b_in;
      a_ff <= a_in;
      y0_ff <= y0_in;
      kprod_ff <= kprod_in;
      term_ff <= term_in;
      snew_ff <= snew_in;
      fit_ff <= fit_in;
      out_y_ff <= out_y_in;
      out_s_ff <= out_s_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign fit_status = fit_ff;
   assign out_y = out_y_ff;
   assign out_stress = out_s_ff;
   assign out_last = out_last_ff;

endmodule

FILE: src/bspf_ctrl.sv
// ----------------------------------------------------------------------------
// bspf_ctrl
// sequencer: point accumulation, end-of-profile tests, divisions, result beats
// ----------------------------------------------------------------------------
`include "bilinear_stress_profile_fit_assert.svh"

module bspf_ctrl
   import bspf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  logic    in_last,
   output logic    in_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_MUL    = 12'b0000_0000_0010,
      ST_ACC    = 12'b0000_0000_0100,
      ST_EVAL   = 12'b0000_0000_1000,
      ST_DECIDE = 12'b0000_0001_0000,
      ST_DIV    = 12'b0000_0010_0000,
      ST_BAND   = 12'b0000_0100_0000,
      ST_KMUL   = 12'b0000_1000_0000,
      ST_DIVP   = 12'b0001_0000_0000,
      ST_TERM   = 12'b0010_0000_0000,
      ST_KINK   = 12'b0100_0000_0000,
      ST_EMIT   = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      DPH_RATIO, DPH_TERM, DPH_FORCE
   } dph_type;

   state_type  state_ff, state_in;
   dph_type    dph_ff, dph_in;
   fit_type    kind_ff, kind_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] idx_ff, idx_in;
   logic       use_first_ff, use_first_in;
   logic       last_ff, last_in;
   logic       open_ff, open_in;
   logic       final_beat;

   always_comb begin
      state_in = state_ff;
      dph_in = dph_ff;
      kind_in = kind_ff;
      step_in = step_ff;
      idx_in = idx_ff;
      use_first_in = use_first_ff;
      last_in = last_ff;
      open_in = open_ff;
      in_ready = 1'b0;
      final_beat = 1'b0;
      cmd.op = OP_NONE;
      cmd.step = step_ff;
      cmd.use_first = use_first_ff;
      cmd.sel = SEL_FAIL;
      cmd.fit = kind_ff;

      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               last_in = in_last;
               open_in = !in_last;
               if (!open_ff) begin
                  cmd.op = OP_FIRST;
                  if (in_last) begin
                     kind_in = FIT_FAIL;
                     idx_in = 2'd0;
                     state_in = ST_EMIT;
                  end
               end else begin
                  cmd.op = OP_LOAD;
                  step_in = 3'd0;
                  use_first_in = 1'b0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.op = OP_MUL;
            if (step_ff == 3'd5) begin
               state_in = use_first_ff ? ST_EVAL : ST_ACC;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_ACC: begin
            cmd.op = OP_ACC;
            if (last_ff) begin
               use_first_in = 1'b1;
               step_in = 3'd0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EVAL: begin
            cmd.op = OP_EVAL;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            idx_in = 2'd0;
            if (sts.nsmall && sts.a_gt) begin
               kind_in = FIT_FAIL;
               state_in = ST_EMIT;
            end else if (sts.nsmall && sts.a_lt) begin
               kind_in = FIT_LIN;
               state_in = ST_EMIT;
            end else if (sts.b_zero) begin
               kind_in = FIT_FAIL;
               state_in = ST_EMIT;
            end else begin
               cmd.op = OP_DIV_A;
               dph_in = DPH_RATIO;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               case (dph_ff)
                  DPH_RATIO: state_in = ST_BAND;
                  DPH_TERM:  state_in = ST_TERM;
                  default:   state_in = ST_KINK;
               endcase
            end
         end
         ST_BAND: begin
            cmd.op = OP_BAND;
            if (sts.pass_band) begin
               state_in = ST_KMUL;
            end else begin
               kind_in = FIT_FAIL;
               idx_in = 2'd0;
               state_in = ST_EMIT;
            end
         end
         ST_KMUL: begin
            cmd.op = OP_KMUL;
            state_in = ST_DIVP;
         end
         ST_DIVP: begin
            cmd.op = OP_DIV_P;
            dph_in = DPH_TERM;
            state_in = ST_DIV;
         end
         ST_TERM: begin
            // takes the slope term and starts the force quotient
            cmd.op = OP_TERM;
            dph_in = DPH_FORCE;
            state_in = ST_DIV;
         end
         ST_KINK: begin
            cmd.op = OP_KINK;
            kind_in = FIT_BIL;
            idx_in = 2'd0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            case (kind_ff)
               FIT_LIN: begin
                  cmd.sel = (idx_ff == 2'd0) ? SEL_FIRST : SEL_LAST;
                  final_beat = idx_ff == 2'd1;
               end
               FIT_BIL: begin
                  cmd.sel = (idx_ff == 2'd0) ? SEL_FIRST :
                            (idx_ff == 2'd1) ? SEL_KINK : SEL_LAST;
                  final_beat = idx_ff == 2'd2;
               end
               default: begin
                  cmd.sel = SEL_FAIL;
                  final_beat = 1'b1;
               end
            endcase
            if (sts.out_free) begin
               cmd.op = OP_EMIT;
               idx_in = idx_ff + 2'd1;
               if (final_beat) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         open_ff <= 1'b0;
         use_first_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         open_ff <= open_in;
         use_first_ff <= use_first_in;
         step_ff <= step_in;
      end
      dph_ff <= dph_in;
      kind_ff <= kind_in;
      idx_ff <= idx_in;
      last_ff <= last_in;
   end

   `BSPF_ASSERT_IMP(a_div_started, $rose(state_ff == ST_DIV), sts.div_busy, "divider not running")
   `BSPF_ASSERT_NXT(a_single_fail, state_ff == ST_IDLE && in_valid && !open_ff && in_last, state_ff == ST_EMIT && kind_ff == FIT_FAIL, "single point not failed")
   `BSPF_ASSERT_IMP(a_emit_closed, state_ff == ST_EMIT, !open_ff, "emitting with profile open")

endmodule
